>>> hw/rtl/gsp_pkg.sv
package gsp_pkg;

  // plane geometry
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_WIDTH  = 64;
  localparam int PIXEL_BITS = 16;
  localparam int DEPTH      = MAX_HEIGHT * MAX_WIDTH;
  localparam int STORE_AW   = $clog2(DEPTH);

  // field widths
  localparam int DIM_W  = 7;
  localparam int ADDR_W = 12;
  localparam int GRID_W = 16;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int IDX_W  = (ROW_W > COL_W) ? ROW_W : COL_W;

  // position: (g + 1.0) * (size - 1), 15 fractional bits
  localparam int FRAC   = 15;
  localparam int P_W    = GRID_W + 1 + IDX_W + 1;
  localparam int WT_W   = 17;
  localparam int SH_W   = 9;

  // register indexes
  localparam logic [1:0] REG_SAMPLE_MODE = 2'd0;
  localparam logic [1:0] REG_PAD_MODE    = 2'd1;
  localparam logic [1:0] REG_HEIGHT      = 2'd2;
  localparam logic [1:0] REG_WIDTH       = 2'd3;

  // commands and modes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_SAMPLE  = 1'b1;
  localparam logic MODE_NEAR   = 1'b0;
  localparam logic MODE_BILIN  = 1'b1;
  localparam logic PAD_ZEROS   = 1'b0;
  localparam logic PAD_BORDER  = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  // one axis after mapping
  typedef struct packed {
    idx_t             i0;
    idx_t             i1;
    logic [SH_W-1:0]  s;
    logic             oob;
  } axis_t;

  // zero acts as one, above max acts as max
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] mx);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > mx) r = mx;
    return r;
  endfunction

endpackage

>>> hw/rtl/gsp_ram.sv
module gsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/gsp_coord.sv
module gsp_coord (
  input  logic signed [gsp_pkg::P_W-1:0] pos,
  input  gsp_pkg::idx_t                  sm1,
  input  logic                           sample_mode,
  input  logic                           pad_mode,
  output gsp_pkg::axis_t                 axis
);

  localparam int P_W = gsp_pkg::P_W;
  localparam int FR  = gsp_pkg::FRAC;
  localparam int IW  = gsp_pkg::IDX_W;

  logic signed [P_W-1:0] max_pos;
  logic                  b_below, b_above;
  logic signed [P_W-1:0] pc;
  gsp_pkg::idx_t         b_i0, b_i1;
  logic [FR-1:0]         frac;
  logic [FR:0]           frac_rnd;
  logic                  n_below, n_above;
  logic signed [P_W-1:0] n_sum;
  logic [P_W-FR-1:0]     n_r;
  gsp_pkg::idx_t         n_idx;

  assign max_pos = $signed({{(P_W-IW-FR){1'b0}}, sm1, {FR{1'b0}}});

  // bilinear: floor/ceil pair and rounded 8-bit fraction
  always_comb begin
    b_below = pos < 0;
    b_above = pos > max_pos;
    pc = pos;
    if (pad_mode == gsp_pkg::PAD_BORDER) begin
      if (b_below) pc = '0;
      else if (b_above) pc = max_pos;
    end
    b_i0 = pc[FR +: IW];
    frac = pc[FR-1:0];
    b_i1 = ((frac != '0) && (b_i0 < sm1)) ? b_i0 + IW'(1) : b_i0;
    frac_rnd = {1'b0, frac} + (FR+1)'(64);
  end

  // nearest: round half away from zero
  always_comb begin
    n_below = pos <= -$signed(P_W'(16384));
    n_sum = pos + $signed(P_W'(16384));
    n_r = (pos < 0) ? '0 : n_sum[P_W-1:FR];
    n_above = !n_below && (n_r > (P_W-FR)'(sm1));
    n_idx = n_r[IW-1:0];
    if (pad_mode == gsp_pkg::PAD_BORDER) begin
      if (n_below) n_idx = '0;
      else if (n_above) n_idx = sm1;
    end
  end

  always_comb begin
    if (sample_mode == gsp_pkg::MODE_BILIN) begin
      axis.i0  = b_i0;
      axis.i1  = b_i1;
      axis.s   = frac_rnd[FR:7];
      axis.oob = (pad_mode == gsp_pkg::PAD_ZEROS) && (b_below || b_above);
    end else begin
      axis.i0  = n_idx;
      axis.i1  = n_idx;
      axis.s   = '0;
      axis.oob = (pad_mode == gsp_pkg::PAD_ZEROS) && (n_below || n_above);
    end
  end

endmodule

>>> hw/rtl/gsp_blend.sv
module gsp_blend (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [gsp_pkg::PIXEL_BITS-1:0] px [4],
  input  logic [gsp_pkg::WT_W-1:0]              wt [4],
  output logic signed [gsp_pkg::PIXEL_BITS-1:0] value
);

  localparam int PB   = gsp_pkg::PIXEL_BITS;
  localparam int PR_W = gsp_pkg::WT_W + 1 + PB;
  localparam int AC_W = PR_W + 2;
  localparam int RS_W = AC_W - 16;

  logic signed [PR_W-1:0] prod_r [4];
  logic signed [AC_W-1:0] acc;
  logic signed [RS_W-1:0] rnd;

  // one weight times one pixel per lane
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= $signed({1'b0, wt[i]}) * px[i];
      end
    end
  end

  // sum, round half up, saturate
  always_comb begin
    acc = AC_W'(prod_r[0]) + AC_W'(prod_r[1]) + AC_W'(prod_r[2])
        + AC_W'(prod_r[3]) + $signed(AC_W'(32768));
    rnd = acc[AC_W-1:16];
    if (rnd > $signed(RS_W'(32767))) value = 16'sh7fff;
    else if (rnd < -$signed(RS_W'(32768))) value = 16'sh8000;
    else value = rnd[PB-1:0];
  end

endmodule

>>> hw/rtl/grid_sample_plane.sv
// grid_sample_plane: samples a stored image plane at normalized grid points.
// input channel (in_valid/in_ready): in_cmd load writes in_pixel_value at
// in_pixel_addr into the plane store and gives no result; in_cmd sample maps
// in_grid_x/in_grid_y (Q2.14, -1..1 spans the corner pixels) into the plane
// and reads it by nearest or bilinear per sample_mode.
// result channel (out_valid/out_ready): out_sample_value (Q8.8, saturated)
// and out_outside, one transaction per sample, in order.
// cfg port: cfg_wr_en/cfg_index/cfg_wdata, write only while idle.
// a sample passes through the position, index, store and product stages
// and the output register before it shows. throughput: one transaction per
// cycle while the pipeline is not held; the four corner pixels are read from
// four copies of the store, each one registered read port, all at once.
// a load written in one cycle is seen by any sample accepted after it.
// reset: sample_mode bilinear, pad_mode zeros, 64x64 plane, pipeline empty;
// the plane store is not cleared and must be loaded before it is sampled.
// when out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
module grid_sample_plane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_cmd,
  input  logic [gsp_pkg::ADDR_W-1:0]            in_pixel_addr,
  input  logic signed [gsp_pkg::PIXEL_BITS-1:0] in_pixel_value,
  input  logic signed [gsp_pkg::GRID_W-1:0]     in_grid_x,
  input  logic signed [gsp_pkg::GRID_W-1:0]     in_grid_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gsp_pkg::PIXEL_BITS-1:0] out_sample_value,
  output logic                                  out_outside,
  input  logic                                  cfg_wr_en,
  input  logic [1:0]                            cfg_index,
  input  logic [gsp_pkg::DIM_W-1:0]             cfg_wdata
);

  localparam int PB = gsp_pkg::PIXEL_BITS;
  localparam int DW = gsp_pkg::DIM_W;
  localparam int IW = gsp_pkg::IDX_W;
  localparam int AW = gsp_pkg::STORE_AW;
  localparam int GW = gsp_pkg::GRID_W;
  localparam int PW = gsp_pkg::P_W;
  localparam int WW = gsp_pkg::WT_W;
  localparam int SW = gsp_pkg::SH_W;

  // config registers
  logic          sample_mode_r, pad_mode_r;
  logic [DW-1:0] height_r, width_r;
  logic [DW-1:0] h_eff, w_eff;
  gsp_pkg::idx_t hm1, wm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_mode_r <= gsp_pkg::MODE_BILIN;
      pad_mode_r    <= gsp_pkg::PAD_ZEROS;
      height_r      <= DW'(gsp_pkg::MAX_HEIGHT);
      width_r       <= DW'(gsp_pkg::MAX_WIDTH);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gsp_pkg::REG_SAMPLE_MODE: sample_mode_r <= cfg_wdata[0];
        gsp_pkg::REG_PAD_MODE:    pad_mode_r    <= cfg_wdata[0];
        gsp_pkg::REG_HEIGHT:      height_r      <= cfg_wdata;
        gsp_pkg::REG_WIDTH:       width_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign h_eff = gsp_pkg::eff_dim(height_r, DW'(gsp_pkg::MAX_HEIGHT));
  assign w_eff = gsp_pkg::eff_dim(width_r, DW'(gsp_pkg::MAX_WIDTH));
  assign hm1   = IW'(h_eff - DW'(1));
  assign wm1   = IW'(w_eff - DW'(1));

  // pipeline advance
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage 1: positions (g + 1.0) * (size - 1)
  logic                 s1_v_r, s1_smp_r;
  logic [gsp_pkg::ADDR_W-1:0] s1_addr_r;
  logic signed [PB-1:0] s1_val_r;
  logic signed [PW-1:0] s1_px_r, s1_py_r;
  logic signed [GW:0]   gx, gy;

  assign gx = {in_grid_x[GW-1], in_grid_x} + $signed((GW+1)'(16384));
  assign gy = {in_grid_y[GW-1], in_grid_y} + $signed((GW+1)'(16384));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_smp_r  <= in_cmd == gsp_pkg::CMD_SAMPLE;
      s1_addr_r <= in_pixel_addr;
      s1_val_r  <= in_pixel_value;
      s1_px_r   <= PW'(gx) * PW'($signed({1'b0, wm1}));
      s1_py_r   <= PW'(gy) * PW'($signed({1'b0, hm1}));
    end
  end

  // stage 2: indices, fractions, outside flag
  gsp_pkg::axis_t ax_x, ax_y;

  gsp_coord u_coord_x (
    .pos         (s1_px_r),
    .sm1         (wm1),
    .sample_mode (sample_mode_r),
    .pad_mode    (pad_mode_r),
    .axis        (ax_x)
  );

  gsp_coord u_coord_y (
    .pos         (s1_py_r),
    .sm1         (hm1),
    .sample_mode (sample_mode_r),
    .pad_mode    (pad_mode_r),
    .axis        (ax_y)
  );

  logic                 s2_v_r, s2_smp_r;
  logic [gsp_pkg::ADDR_W-1:0] s2_addr_r;
  logic signed [PB-1:0] s2_val_r;
  gsp_pkg::axis_t       s2_x_r, s2_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_smp_r  <= s1_smp_r;
      s2_addr_r <= s1_addr_r;
      s2_val_r  <= s1_val_r;
      s2_x_r    <= ax_x;
      s2_y_r    <= ax_y;
    end
  end

  // stage 3: store access, corner addresses and weights
  logic [AW-1:0]   raddr [4];
  logic [WW-1:0]   wt_nxt [4];
  logic [SW-1:0]   ish, isw;
  logic            st_we;
  logic [PB-1:0]   rdata [4];

  assign raddr[0] = AW'(s2_y_r.i0) * AW'(w_eff) + AW'(s2_x_r.i0);
  assign raddr[1] = AW'(s2_y_r.i1) * AW'(w_eff) + AW'(s2_x_r.i0);
  assign raddr[2] = AW'(s2_y_r.i0) * AW'(w_eff) + AW'(s2_x_r.i1);
  assign raddr[3] = AW'(s2_y_r.i1) * AW'(w_eff) + AW'(s2_x_r.i1);

  assign ish = SW'(256) - s2_y_r.s;
  assign isw = SW'(256) - s2_x_r.s;
  assign wt_nxt[0] = WW'(ish) * WW'(isw);
  assign wt_nxt[1] = WW'(s2_y_r.s) * WW'(isw);
  assign wt_nxt[2] = WW'(ish) * WW'(s2_x_r.s);
  assign wt_nxt[3] = WW'(s2_y_r.s) * WW'(s2_x_r.s);

  assign st_we = adv && s2_v_r && !s2_smp_r
              && ({1'b0, s2_addr_r} < (gsp_pkg::ADDR_W+1)'(gsp_pkg::DEPTH));

  for (genvar k = 0; k < 4; k++) begin : g_bank
    gsp_ram #(
      .WIDTH (PB),
      .DEPTH (gsp_pkg::DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (st_we),
      .waddr (s2_addr_r[AW-1:0]),
      .wdata (s2_val_r),
      .re    (adv),
      .raddr (raddr[k]),
      .rdata (rdata[k])
    );
  end

  logic          s3_v_r, s3_oob_r;
  logic [WW-1:0] s3_wt_r [4];
  logic signed [PB-1:0] s3_px [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r && s2_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_oob_r <= s2_x_r.oob || s2_y_r.oob;
      for (int i = 0; i < 4; i++) begin
        s3_wt_r[i] <= wt_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s3_px[i] = $signed(rdata[i]);
    end
  end

  // stage 4: products, then sum and round into the output register
  logic                 s4_v_r, s4_oob_r;
  logic signed [PB-1:0] blend_val;

  gsp_blend u_blend (
    .clk   (clk),
    .en    (adv),
    .px    (s3_px),
    .wt    (s3_wt_r),
    .value (blend_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_oob_r <= s3_oob_r;
    end
  end

  // output register
  logic signed [PB-1:0] out_val_r;
  logic                 out_oob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_oob_r <= s4_oob_r;
      out_val_r <= s4_oob_r ? '0 : blend_val;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_val_r;
  assign out_outside      = out_oob_r;

  // checks
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outside |-> out_sample_value == '0)
    else $error("outside result carries a nonzero value");

  a_border_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (pad_mode_r == gsp_pkg::PAD_BORDER) |-> !out_outside)
    else $error("border padding flagged a point outside");

  a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == gsp_pkg::CMD_SAMPLE) |=> s1_v_r && s1_smp_r)
    else $error("accepted sample lost at the first stage");

endmodule
